// ----- hw/rtl/rgbf_pkg.sv -----
// shared types and constants of the rgb box filter
package rgbf_pkg;

	localparam int K_W    = 3;
	localparam int DIM_W  = 12;
	localparam int CFG_W  = 12;
	localparam int PEND_W = 16;
	localparam int SUM_W  = 14;
	localparam int DEN_W  = 6;
	localparam int CH_W   = 8;

	localparam logic [1:0] CFG_KERNEL = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam logic [PEND_W-1:0] PEND_MAX = '1;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [CH_W-1:0]  chan_t;

endpackage

// ----- hw/rtl/rgb_box_filter_unit.sv -----
// rgb box filter: k x k mean per channel over a raster pixel stream
// Input channel (in_valid/in_ready) carries a command and one pixel. A pixel
// transfer writes the line store; once s = (k-1)/2 rows plus s pixels are
// buffered, each pixel transfer yields one result. After a frame, drain
// transfers (command = 1) flush the pending results, one each.
// Result channel (out_valid/out_ready) sits behind an output register, so a
// new input is taken while the last result waits for the receiver.
// An item that yields no result leaves in_ready high. A border or
// pass-through result reads one line store entry; a window mean reads
// k*k entries through the single read port, then the divider takes 14
// steps. in_ready stays low from the transfer until the result moves
// into the output register. A stalled receiver holds further results
// in the pipe and lowers in_ready until the output register frees.
// Reset clears counters, config (k=3, 640x480) and handshake state; the
// line store is not cleared and is valid only where written.
// Even kernel sizes drop every item without a result.
// cfg_we writes register cfg_index (0 kernel, 1 width, 2 height) at once.
module rgb_box_filter_unit #(
	parameter int MAX_KERNEL = 7,
	parameter int MAX_WIDTH  = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [rgbf_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [7:0]                    in_red,
	input  logic [7:0]                    in_green,
	input  logic [7:0]                    in_blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_blue,
	output logic                          was_averaged,
	output logic                          frame_end
);
	import rgbf_pkg::*;

	localparam int DEPTH  = MAX_KERNEL * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int SLOT_W = $clog2(MAX_KERNEL);
	localparam int LAG_W  = W_W + K_W;
	localparam logic [K_W-1:0] K_CLAMP = K_W'((MAX_KERNEL - 1) | 1);

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_LAST, ST_DIV, ST_HOLD} state_t;

	state_t state_q;

	logic [K_W-1:0]    kernel_q;
	logic [DIM_W-1:0]  width_q, height_q;

	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic [DIM_W-1:0]  out_row_q;
	logic [PEND_W-1:0] pending_q;

	logic [SLOT_W-1:0] rd_slot_q;
	logic [COL_W-1:0]  col0_q;
	logic [K_W-1:0]    rd_col_q, rd_row_q, side_q;
	logic              border_q, fend_q, rd_s1;
	logic [DEN_W-1:0]  den_q;
	sum_t              acc_q [3];
	sum_t              sum_fin [3];

	pixel_t            res_q;
	logic              res_avg_q, res_fend_q;

	logic [K_W-1:0]    k_eff;
	logic [K_W-1:0]    s_eff;
	logic              k_odd;
	logic [W_W-1:0]    w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [LAG_W-1:0]  lag;
	logic [PEND_W-1:0] pend_inc;
	logic              act, emit_go, border_n, fend_n, col_wrap, in_wrap, last_issue;
	logic [SLOT_W-1:0] slot_start;
	logic [COL_W-1:0]  col0_n;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] waddr, raddr;
	pixel_t            wdata, rdata;

	logic              div_start, div_done;
	chan_t             quot [3];

	always_comb begin
		int sl;
		k_eff = (int'(kernel_q) > MAX_KERNEL) ? K_CLAMP : kernel_q;
		k_odd = k_eff[0];
		s_eff = (k_eff - 1'b1) >> 1;
		if (width_q == '0) begin
			w_eff = W_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = W_W'(MAX_WIDTH);
		end else begin
			w_eff = W_W'(width_q);
		end
		h_eff    = (height_q == '0) ? DIM_W'(1) : height_q;
		lag      = LAG_W'(s_eff) * LAG_W'(w_eff) + LAG_W'(s_eff);
		pend_inc = (pending_q == PEND_MAX) ? pending_q : pending_q + 1'b1;

		act     = in_valid && in_ready && k_odd;
		emit_go = act && (command ? (pending_q != '0) : (int'(pend_inc) > int'(lag)));
		in_wrap = int'(in_col_q) + 1 >= int'(w_eff);

		border_n = int'(w_eff) < int'(k_eff) || int'(h_eff) < int'(k_eff)
			|| int'(out_row_q) < int'(s_eff)
			|| int'(out_row_q) + int'(s_eff) >= int'(h_eff)
			|| int'(out_col_q) < int'(s_eff)
			|| int'(out_col_q) + int'(s_eff) >= int'(w_eff);
		col_wrap = int'(out_col_q) + 1 >= int'(w_eff);
		fend_n   = col_wrap && (int'(out_row_q) + 1 >= int'(h_eff));
		sl = int'(out_slot_q) + MAX_KERNEL - int'(s_eff);
		if (sl >= MAX_KERNEL) begin
			sl = sl - MAX_KERNEL;
		end
		slot_start = border_n ? out_slot_q : SLOT_W'(sl);
		col0_n     = border_n ? out_col_q : out_col_q - COL_W'(s_eff);

		last_issue = (rd_col_q == side_q - 1'b1) && (rd_row_q == side_q - 1'b1);
		for (int i = 0; i < 3; i++) begin
			sum_fin[i] = acc_q[i];
		end
		sum_fin[0] = acc_q[0] + SUM_W'(rdata.red);
		sum_fin[1] = acc_q[1] + SUM_W'(rdata.green);
		sum_fin[2] = acc_q[2] + SUM_W'(rdata.blue);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign mem_we    = act && !command;
	assign waddr     = ADDR_W'(in_slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_q);
	assign wdata     = '{red: in_red, green: in_green, blue: in_blue};
	assign mem_re    = (state_q == ST_READ);
	assign raddr     = ADDR_W'(rd_slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col0_q)
		+ ADDR_W'(rd_col_q);
	assign div_start = (state_q == ST_LAST) && !border_q;

	rgbf_line_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	rgbf_div3 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_fin),
		.den    (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	// config, counters, sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kernel_q   <= K_W'(3);
			width_q    <= DIM_W'(640);
			height_q   <= DIM_W'(480);
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pending_q  <= '0;
			rd_s1      <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_KERNEL: kernel_q <= cfg_data[K_W-1:0];
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			if (mem_we) begin
				if (in_wrap) begin
					in_col_q  <= '0;
					in_slot_q <= (int'(in_slot_q) == MAX_KERNEL - 1) ? '0 : in_slot_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end

			if (act) begin
				if (emit_go) begin
					pending_q <= (command ? pending_q : pend_inc) - 1'b1;
				end else if (!command) begin
					pending_q <= pend_inc;
				end
			end

			if (emit_go) begin
				if (col_wrap) begin
					out_col_q  <= '0;
					out_slot_q <= (int'(out_slot_q) == MAX_KERNEL - 1) ? '0
						: out_slot_q + 1'b1;
					out_row_q  <= (int'(out_row_q) + 1 >= int'(h_eff)) ? '0
						: out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end

			rd_s1 <= (state_q == ST_READ);

			// load a new result or retire the one just transferred
			if (state_q == ST_HOLD && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (emit_go) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (last_issue) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= border_q ? ST_HOLD : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!out_valid || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read walk over the window and result payload
	always_ff @(posedge clk) begin
		if (emit_go) begin
			rd_slot_q <= slot_start;
			col0_q    <= col0_n;
			rd_col_q  <= '0;
			rd_row_q  <= '0;
			side_q    <= border_n ? K_W'(1) : k_eff;
			border_q  <= border_n;
			fend_q    <= fend_n;
			den_q     <= DEN_W'(k_eff) * DEN_W'(k_eff);
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_READ) begin
				if (rd_col_q == side_q - 1'b1) begin
					rd_col_q  <= '0;
					rd_row_q  <= rd_row_q + 1'b1;
					rd_slot_q <= (int'(rd_slot_q) == MAX_KERNEL - 1) ? '0 : rd_slot_q + 1'b1;
				end else begin
					rd_col_q <= rd_col_q + 1'b1;
				end
			end
			if (rd_s1) begin
				acc_q <= sum_fin;
			end
		end

		if (state_q == ST_LAST && border_q) begin
			res_q     <= rdata;
			res_avg_q <= 1'b0;
		end
		if (state_q == ST_DIV && div_done) begin
			res_q     <= '{red: quot[0], green: quot[1], blue: quot[2]};
			res_avg_q <= 1'b1;
		end
		res_fend_q <= fend_q;

		if (state_q == ST_HOLD && (!out_valid || out_ready)) begin
			out_red      <= res_q.red;
			out_green    <= res_q.green;
			out_blue     <= res_q.blue;
			was_averaged <= res_avg_q;
			frame_end    <= res_fend_q;
		end
	end

endmodule

// ----- hw/rtl/rgbf_line_mem.sv -----
// line store: one write port, one registered read port
module rgbf_line_mem #(
	parameter int DEPTH  = 14336,
	parameter int ADDR_W = 14
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  rgbf_pkg::pixel_t      wdata,
	input  logic                  re,
	input  logic [ADDR_W-1:0]     raddr,
	output rgbf_pkg::pixel_t      rdata
);
	import rgbf_pkg::*;

	pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/rgbf_div3.sv -----
// three-lane restoring divider, one quotient bit per cycle
module rgbf_div3 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  rgbf_pkg::sum_t            num [3],
	input  logic [rgbf_pkg::DEN_W-1:0] den,
	output logic                      done,
	output rgbf_pkg::chan_t           quot [3]
);
	import rgbf_pkg::*;

	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q [3];
	sum_t             sh_q [3];
	logic [DEN_W:0]   trial [3];
	logic             ge [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], sh_q[i][SUM_W-1]};
			ge[i]    = trial[i] >= {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= busy_q && !start && (cnt_q == CNT_W'(SUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
				sh_q[i]  <= num[i];
			end
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ge[i] ? DEN_W'(trial[i] - {1'b0, den_q}) : trial[i][DEN_W-1:0];
				sh_q[i]  <= {sh_q[i][SUM_W-2:0], ge[i]};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quot[i] = sh_q[i][CH_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/rgbf_checker.sv -----
// port-level checks of the rgb box filter, bound to the top level
module rgbf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic       was_averaged,
	input logic       frame_end
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(was_averaged) && $stable(frame_end))
		else $error("result changed while stalled");

	// a result is loaded only while the input side is busy
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while input was open");

	// an input transfer never produces a result in the next cycle
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early after input transfer");

endmodule

bind rgb_box_filter_unit rgbf_checker u_rgbf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_red      (out_red),
	.out_green    (out_green),
	.out_blue     (out_blue),
	.was_averaged (was_averaged),
	.frame_end    (frame_end)
);

// ----- dv/tb.sv -----
// testbench for the rgb box filter: frames of random pixels checked against a predictor
`timescale 1ns / 100ps

module tb;
	import rgbf_pkg::*;

	typedef struct {
		pixel_t pix;
		bit     avg;
		bit     fend;
	} filt_result_t;

	// predicts the filtered stream and checks each result transfer
	class filter_scoreboard;
		localparam int NK = 7;
		localparam int NW = 2048;
		bit [23:0]      rows [NK*NW];
		int unsigned    in_col, in_row, out_col, out_row, in_slot, out_slot;
		int unsigned    pending;
		bit [K_W-1:0]   k_reg;
		bit [DIM_W-1:0] w_reg, h_reg;
		filt_result_t   exp_q[$];
		int             errors;

		function new();
			foreach (rows[i]) rows[i] = '0;
			in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			in_slot = 0; out_slot = 0; pending = 0;
			k_reg = 3; w_reg = 640; h_reg = 480;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, bit [CFG_W-1:0] val);
			if (idx == CFG_KERNEL) k_reg = val[K_W-1:0];
			else if (idx == CFG_WIDTH) w_reg = val[DIM_W-1:0];
			else if (idx == CFG_HEIGHT) h_reg = val[DIM_W-1:0];
		endfunction

		function int unsigned cur_w();
			int unsigned w;
			w = (w_reg == 0) ? 1 : w_reg;
			return (w > NW) ? NW : w;
		endfunction

		function int unsigned cur_h();
			return (h_reg == 0) ? 1 : h_reg;
		endfunction

		function void emit_pixel(int unsigned k, int unsigned w, int unsigned h);
			int unsigned s, sr, sg, sb, slot;
			bit [23:0] v;
			filt_result_t r;
			s = (k - 1) / 2;
			if (w < k || h < k || out_row < s || out_row + s >= h ||
					out_col < s || out_col + s >= w) begin
				r.pix = rows[out_slot*NW + out_col];
				r.avg = 0;
			end else begin
				sr = 0; sg = 0; sb = 0;
				for (int dr = 0; dr < k; dr++) begin
					slot = (out_slot + NK - s + dr) % NK;
					for (int dc = 0; dc < k; dc++) begin
						v = rows[slot*NW + out_col - s + dc];
						sr += v[23:16]; sg += v[15:8]; sb += v[7:0];
					end
				end
				r.pix.red   = 8'(sr / (k*k));
				r.pix.green = 8'(sg / (k*k));
				r.pix.blue  = 8'(sb / (k*k));
				r.avg = 1;
			end
			r.fend = 0;
			if (out_col + 1 >= w) begin
				out_col = 0;
				out_slot = (out_slot + 1) % NK;
				if (out_row + 1 >= h) begin
					out_row = 0;
					r.fend = 1;
				end else begin
					out_row++;
				end
			end else begin
				out_col++;
			end
			if (pending > 0) pending--;
			exp_q.push_back(r);
		endfunction

		function void note_input(bit cmd, bit [7:0] r, bit [7:0] g, bit [7:0] b);
			int unsigned k, w, h, s;
			k = k_reg; w = cur_w(); h = cur_h();
			if (k[0] == 0) return;
			s = (k - 1) / 2;
			if (cmd) begin
				if (pending != 0) emit_pixel(k, w, h);
				return;
			end
			rows[in_slot*NW + in_col] = {r, g, b};
			if (in_col + 1 >= w) begin
				in_col = 0;
				in_slot = (in_slot + 1) % NK;
				in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
			end else begin
				in_col++;
			end
			if (pending < 16'hFFFF) pending++;
			if (pending > s*w + s) emit_pixel(k, w, h);
		endfunction

		function void check_result(pixel_t pix, bit avg, bit fend);
			filt_result_t e;
			if (exp_q.size() == 0) begin
				$error("unexpected result %h avg=%0b end=%0b", pix, avg, fend);
				errors++;
				return;
			end
			e = exp_q.pop_front();
			if (pix.red !== e.pix.red) begin
				$error("out_red exp %0d got %0d", e.pix.red, pix.red); errors++;
			end
			if (pix.green !== e.pix.green) begin
				$error("out_green exp %0d got %0d", e.pix.green, pix.green); errors++;
			end
			if (pix.blue !== e.pix.blue) begin
				$error("out_blue exp %0d got %0d", e.pix.blue, pix.blue); errors++;
			end
			if (avg !== e.avg) begin
				$error("was_averaged exp %0b got %0b", e.avg, avg); errors++;
			end
			if (fend !== e.fend) begin
				$error("frame_end exp %0b got %0b", e.fend, fend); errors++;
			end
		endfunction
	endclass

	logic             clk = 0;
	logic             arst_n = 0;
	logic             cfg_we = 0;
	logic [1:0]       cfg_index = CFG_KERNEL;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 0;
	logic             in_ready;
	logic             command = 0;
	logic [7:0]       in_red = 0, in_green = 0, in_blue = 0;
	logic             out_valid;
	logic             out_ready = 0;
	logic [7:0]       out_red, out_green, out_blue;
	logic             was_averaged, frame_end;

	filter_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_rx = 0;
	int quiet_cycles = 0;
	int total_items = 0;

	rgb_box_filter_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.was_averaged(was_averaged), .frame_end(frame_end)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk) begin
		out_ready = !hold_rx && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result({out_red, out_green, out_blue}, was_averaged, frame_end);
			if (in_valid && in_ready)
				sb.note_input(command, in_red, in_green, in_blue);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic bit [7:0] pick_chan();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_item(bit cmd, bit [7:0] r, bit [7:0] g, bit [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		command = cmd;
		in_red = r; in_green = g; in_blue = b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		total_items++;
	endtask

	// hold the sender until every expected result has come out
	task automatic wait_results();
		in_valid = 0;
		while (sb.exp_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic configure(int k, int w, int h);
		wait_results();
		cfg_we = 1;
		cfg_index = CFG_KERNEL; cfg_data = CFG_W'(k); sb.set_reg(CFG_KERNEL, CFG_W'(k));
		@(negedge clk);
		cfg_index = CFG_WIDTH; cfg_data = CFG_W'(w); sb.set_reg(CFG_WIDTH, CFG_W'(w));
		@(negedge clk);
		cfg_index = CFG_HEIGHT; cfg_data = CFG_W'(h); sb.set_reg(CFG_HEIGHT, CFG_W'(h));
		@(negedge clk);
		cfg_we = 0;
	endtask

	// whole frame of pixels, then drains to flush what is pending
	task automatic run_frame(int k, int w, int h, bit fixed_val, bit [7:0] val);
		int n;
		configure(k, w, h);
		n = sb.cur_w() * sb.cur_h();
		for (int i = 0; i < n; i++) begin
			if (fixed_val) send_item(0, val, val, val);
			else send_item(0, pick_chan(), pick_chan(), pick_chan());
		end
		n = sb.pending + $urandom_range(2);
		for (int i = 0; i < n; i++)
			send_item(1, pick_chan(), pick_chan(), pick_chan());
	endtask

	// start of one row only, then drains; leaves the raster position mid-row
	task automatic run_row_part(int k, int w, int h, int n_pix);
		int n;
		configure(k, w, h);
		for (int i = 0; i < n_pix; i++)
			send_item(0, pick_chan(), pick_chan(), pick_chan());
		n = sb.pending;
		for (int i = 0; i < n; i++)
			send_item(1, pick_chan(), pick_chan(), pick_chan());
	endtask

	initial begin
		int k;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// drain with nothing pending, at reset config
		send_item(1, 8'hFF, 8'h00, 8'hFF);
		run_frame(3, 4, 4, 1, 8'hFF);
		run_frame(3, 4, 4, 1, 8'h00);
		run_frame(3, 5, 4, 0, 0);
		run_frame(1, 3, 2, 0, 0);
		run_frame(4, 3, 3, 0, 0);   // even kernel drops everything
		run_frame(0, 0, 0, 0, 0);
		run_frame(3, 2, 5, 0, 0);   // frame smaller than the window
		run_frame(7, 7, 7, 0, 0);
		run_frame(3, 1, 40, 0, 0);

		// receiver holds off long while the sender keeps offering
		wait_results();
		fork
			begin
				hold_rx = 1;
				repeat (3000) @(negedge clk);
				hold_rx = 0;
			end
		join_none
		run_frame(3, 8, 8, 0, 0);

		for (int ph = 0; total_items < 1250; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 23; stall_pct = 23; end
			endcase
			case ($urandom_range(9))
				0: k = 2 * $urandom_range(3);
				1: k = 1;
				2, 3: k = 5;
				4: k = 7;
				default: k = 3;
			endcase
			run_frame(k, $urandom_range(12), $urandom_range(10), 0, 0);
		end

		// width clamps to the line length
		run_row_part(7, 4095, 1, 48);

		wait_results();
		if (sb.exp_q.size() != 0) begin
			$error("%0d results never came", sb.exp_q.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
